// File: rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpcodeW = 4;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned HdrCntW = 4;

  localparam logic [7:0] OPCODE_MASK  = 8'h0F;
  localparam logic [7:0] MASK_BIT     = 8'h80;
  localparam logic [7:0] LEN_CODE_MSK = 8'h7F;
  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;

  localparam logic [HdrCntW-1:0] EXT16_BYTES = 4'd2;
  localparam logic [HdrCntW-1:0] EXT64_BYTES = 4'd8;
  localparam logic [HdrCntW-1:0] KEY_BYTES   = 4'd4;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // One result beat from the parser to the output stage.
  typedef struct packed {
    logic               valid;
    logic [OpcodeW-1:0] frame_opcode;
    logic               has_data;
    logic [ByteW-1:0]   payload_byte;
    logic               last_in_frame;
  } result_t;

endpackage

// File: rtl/wsd_in_stage.sv
// Input register stage: holds one received byte until the parser takes it.
module wsd_in_stage
  import wsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_rx_byte,
  input  logic             advance,
  output logic             byte_valid,
  output logic [ByteW-1:0] byte_data
);

  logic             valid_r, valid_nxt;
  logic [ByteW-1:0] byte_r,  byte_nxt;
  logic             load;

  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_rx_byte;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

// File: rtl/wsd_parser.sv
// Frame header parser and payload unmasker, one byte per advance.
module wsd_parser
  import wsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [ByteW-1:0] rx_byte,
  output result_t          result
);

  phase_t             phase_r,  phase_nxt;
  logic [OpcodeW-1:0] opcode_r, opcode_nxt;
  logic               mask_r,   mask_nxt;
  logic [HdrCntW-1:0] hbl_r,    hbl_nxt;
  logic [LenW-1:0]    rem_r,    rem_nxt;
  logic [KeyW-1:0]    key_r,    key_nxt;
  logic [1:0]         pos_r,    pos_nxt;

  logic [6:0]       len_code;
  logic             len_done;
  logic             hdr_done;
  logic [ByteW-1:0] key_byte;
  logic             last;

  assign len_code = 7'(rx_byte & LEN_CODE_MSK);

  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    hbl_nxt    = hbl_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    last       = 1'b0;
    result     = '0;

    case (phase_r)
      PH_HDR1: begin
        mask_nxt = (rx_byte & MASK_BIT) != 8'h00;
        rem_nxt  = '0;
        if (len_code == LEN_CODE_16) begin
          hbl_nxt   = EXT16_BYTES;
          phase_nxt = PH_EXTLEN;
        end else if (len_code == LEN_CODE_64) begin
          hbl_nxt   = EXT64_BYTES;
          phase_nxt = PH_EXTLEN;
        end else begin
          rem_nxt  = {{(LenW-7){1'b0}}, len_code};
          len_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        rem_nxt  = {rem_r[LenW-ByteW-1:0], rx_byte};
        hbl_nxt  = hbl_r - 4'd1;
        len_done = (hbl_nxt == '0);
      end
      PH_KEY: begin
        key_nxt  = {key_r[KeyW-ByteW-1:0], rx_byte};
        hbl_nxt  = hbl_r - 4'd1;
        hdr_done = (hbl_nxt == '0);
      end
      PH_PAYLOAD: begin
        pos_nxt = pos_r + 2'd1;
        rem_nxt = rem_r - 64'd1;
        last    = (rem_nxt == '0);
        if (last) begin
          phase_nxt = PH_HDR0;
        end
        result.valid         = 1'b1;
        result.frame_opcode  = opcode_r;
        result.has_data      = 1'b1;
        result.payload_byte  = rx_byte ^ (mask_r ? key_byte : 8'h00);
        result.last_in_frame = last;
      end
      default: begin
        opcode_nxt = 4'(rx_byte & OPCODE_MASK);
        phase_nxt  = PH_HDR1;
      end
    endcase

    // Length known: fetch the key or finish the header.
    if (len_done) begin
      if (mask_nxt) begin
        key_nxt   = '0;
        hbl_nxt   = KEY_BYTES;
        phase_nxt = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: start payload or send the empty-frame notice.
    if (hdr_done) begin
      pos_nxt = '0;
      if (rem_nxt == '0) begin
        phase_nxt            = PH_HDR0;
        result.valid         = 1'b1;
        result.frame_opcode  = opcode_r;
        result.has_data      = 1'b0;
        result.payload_byte  = '0;
        result.last_in_frame = 1'b1;
      end else begin
        phase_nxt = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      hbl_r    <= '0;
      rem_r    <= '0;
      key_r    <= '0;
      pos_r    <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      hbl_r    <= hbl_nxt;
      rem_r    <= rem_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_returns_to_hdr0 : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.valid && result.last_in_frame) |=> (phase_r == PH_HDR0))
    else $error("frame end did not return to first header byte");

  a_notice_is_empty_last : assert property (@(posedge clk) disable iff (!rst_n)
    (result.valid && !result.has_data) |->
      (result.payload_byte == '0 && result.last_in_frame))
    else $error("empty-frame notice carries data or is not last");

  a_header_count_live : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EXTLEN || phase_r == PH_KEY) |-> (hbl_r != '0))
    else $error("header byte count empty while header bytes are due");

  a_payload_count_live : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (rem_r != '0))
    else $error("payload phase with zero bytes remaining");
`endif

endmodule

// File: rtl/wsd_out_stage.sv
// Output register stage: holds one result beat until the sink takes it.
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  result_t            result,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OpcodeW-1:0] out_frame_opcode,
  output logic               out_has_data,
  output logic [ByteW-1:0]   out_payload_byte,
  output logic               out_last_in_frame
);

  logic    valid_r, valid_nxt;
  result_t data_r,  data_nxt;
  logic    load;

  assign space = !valid_r || out_ready;
  assign load  = advance && result.valid;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = result;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_valid         = valid_r;
  assign out_frame_opcode  = data_r.frame_opcode;
  assign out_has_data      = data_r.has_data;
  assign out_payload_byte  = data_r.payload_byte;
  assign out_last_in_frame = data_r.last_in_frame;

endmodule

// File: rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer.
//
// Receive-side WebSocket deframer: feed the raw stream one byte per beat on
// the in_ channel and collect unmasked payload beats on the out_ channel.
// The block accepts one byte per clock as long as the sink keeps out_ready
// high; a full output register stalls header and payload bytes alike.
// A byte passes an input register, the header parser and unmasking logic,
// and an output register, which holds each payload beat on the out_ ports
// until the sink takes it. The parser handles each byte in a single pass,
// whose longest path is the 64-bit length decrement and zero compare.
// Header bytes (opcode, length, extended length, mask key) produce no beat.
// Each payload byte is tagged with the frame opcode and, in a masked frame,
// XORed with the rolling mask key byte; a frame's final beat carries
// out_last_in_frame. A frame of length zero yields one notice beat with
// out_has_data low and a zero byte. FIN and RSV bits are ignored, and the
// 64-bit length is taken as received.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ByteW-1:0]   in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OpcodeW-1:0] out_frame_opcode,
  output logic               out_has_data,
  output logic [ByteW-1:0]   out_payload_byte,
  output logic               out_last_in_frame
);

  logic             byte_valid;
  logic [ByteW-1:0] byte_data;
  logic             out_space;
  logic             advance;
  result_t          result;

  // Advance the parser when a byte is held and the output stage has room.
  assign advance = byte_valid && out_space;

  wsd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Parse headers, track the length and unmask payload bytes.
  wsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (byte_data),
    .result  (result)
  );

  // Hold each result beat until the sink takes it.
  wsd_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .advance           (advance),
    .result            (result),
    .space             (out_space),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_opcode  (out_frame_opcode),
    .out_has_data      (out_has_data),
    .out_payload_byte  (out_payload_byte),
    .out_last_in_frame (out_last_in_frame)
  );

endmodule
